@@ rtl/bcl_pkg.sv @@
// ----------------------------------------------------------------------------
// bcl_pkg: shared types and constants for the bit-bang command link
// Register indexes, reset values, phase encoding and the timing register set.
// ----------------------------------------------------------------------------
package bcl_pkg;

  // timer and register widths
  localparam int TICK_W    = 16;
  localparam int REG_IDX_W = 3;
  localparam int BIT_IDX_W = 4;
  localparam int CMD_W     = 8;
  localparam int NIB_W     = 4;

  // number of data bits sent, and of bits sampled on receive
  localparam logic [BIT_IDX_W-1:0] DATA_BITS = 4'd8;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_TX_BIT     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TX_ACK     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RX_CONFIRM = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RX_START   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RX_BIT     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RX_HOLD    = 3'd5;

  // register reset values, in ticks
  localparam logic [TICK_W-1:0] RST_TX_BIT     = 16'd104;
  localparam logic [TICK_W-1:0] RST_TX_ACK     = 16'd3000;
  localparam logic [TICK_W-1:0] RST_RX_CONFIRM = 16'd998;
  localparam logic [TICK_W-1:0] RST_RX_START   = 16'd20958;
  localparam logic [TICK_W-1:0] RST_RX_BIT     = 16'd5000;
  localparam logic [TICK_W-1:0] RST_RX_HOLD    = 16'd19960;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_TX_BIT     = 4'd1,
    PH_TX_ACK     = 4'd2,
    PH_RX_CONFIRM = 4'd3,
    PH_RX_START   = 4'd4,
    PH_RX_SAMPLE  = 4'd5,
    PH_RX_HOLD    = 4'd6
  } phase_t;

  // timing register set
  typedef struct packed {
    logic [TICK_W-1:0] tx_bit;
    logic [TICK_W-1:0] tx_ack;
    logic [TICK_W-1:0] rx_confirm;
    logic [TICK_W-1:0] rx_start;
    logic [TICK_W-1:0] rx_bit;
    logic [TICK_W-1:0] rx_hold;
  } cfg_regs_t;

endpackage

@@ rtl/bcl_if.sv @@
// ----------------------------------------------------------------------------
// bcl_if: valid/ready channels of the bit-bang command link
// Tick input channel, per-tick result channel and configuration write channel.
// ----------------------------------------------------------------------------

// tick input: partner line sample plus optional command load
interface bcl_in_if;
  logic                     valid;
  logic                     ready;
  logic                     line_in;
  logic                     load_valid;
  logic [bcl_pkg::CMD_W-1:0] load_command;

  modport source (output valid, line_in, load_valid, load_command, input ready);
  modport sink   (input valid, line_in, load_valid, load_command, output ready);
endinterface

// per-tick result
interface bcl_out_if;
  logic                     valid;
  logic                     ready;
  logic                     tx_line;
  logic                     control_line;
  logic                     tx_done;
  logic                     tx_ok;
  logic                     rx_valid;
  logic [bcl_pkg::NIB_W-1:0] rx_command;
  logic                     busy_res;
  logic                     pending;

  modport source (output valid, tx_line, control_line, tx_done, tx_ok, rx_valid,
                  rx_command, busy_res, pending, input ready);
  modport sink   (input valid, tx_line, control_line, tx_done, tx_ok, rx_valid,
                  rx_command, busy_res, pending, output ready);
endinterface

// configuration register writes
interface bcl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bcl_pkg::REG_IDX_W-1:0] index;
  logic [bcl_pkg::TICK_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bcl_regs.sv @@
// ----------------------------------------------------------------------------
// bcl_regs: timing register file
// Six 16-bit tick counts, written one beat at a time; unknown indexes dropped.
// ----------------------------------------------------------------------------
module bcl_regs (
  input  logic               clk,
  input  logic               rst_n,
  bcl_cfg_if.sink            cfg,
  output bcl_pkg::cfg_regs_t regs_o
);

  bcl_pkg::cfg_regs_t regs_r;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.tx_bit     <= bcl_pkg::RST_TX_BIT;
      regs_r.tx_ack     <= bcl_pkg::RST_TX_ACK;
      regs_r.rx_confirm <= bcl_pkg::RST_RX_CONFIRM;
      regs_r.rx_start   <= bcl_pkg::RST_RX_START;
      regs_r.rx_bit     <= bcl_pkg::RST_RX_BIT;
      regs_r.rx_hold    <= bcl_pkg::RST_RX_HOLD;
    end else if (cfg.valid) begin
      case (cfg.index)
        bcl_pkg::REG_TX_BIT:     regs_r.tx_bit     <= cfg.data;
        bcl_pkg::REG_TX_ACK:     regs_r.tx_ack     <= cfg.data;
        bcl_pkg::REG_RX_CONFIRM: regs_r.rx_confirm <= cfg.data;
        bcl_pkg::REG_RX_START:   regs_r.rx_start   <= cfg.data;
        bcl_pkg::REG_RX_BIT:     regs_r.rx_bit     <= cfg.data;
        bcl_pkg::REG_RX_HOLD:    regs_r.rx_hold    <= cfg.data;
        default: ;
      endcase
    end
  end

  assign regs_o = regs_r;

endmodule

@@ rtl/bitbang_command_link.sv @@
// ----------------------------------------------------------------------------
// bitbang_command_link: timed single-wire command link
// One beat per microsecond tick; sends pending bytes, receives 4-bit commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one beat per tick, carrying the partner line sample and an
//            optional command byte to queue (load_valid/load_command).
//   out_ch : one result beat per input beat, in order: line levels, done and
//            receive pulses, busy and pending flags after that tick.
//   cfg_ch : register writes (index 0..5 = tx_bit, tx_ack, rx_confirm,
//            rx_start, rx_bit, rx_hold ticks); always ready. Write only
//            while no tick result is outstanding.
// Output: the result of a tick is registered and on out_ch in the cycle after the tick beat.
// Throughput: one tick per cycle unless out_ch stalls; the whole tick update is one pass of the
//   phase sequencer between the state registers and the result register.
// Stall: the result register holds its beat while out_ch.ready is low; a new
//   tick is taken in the same cycle the held beat leaves, so in_ch.ready
//   drops only while a result waits and the receiver is stalled.
// Reset (rst_n low, synchronous): idle, nothing pending, both lines high,
//   timing registers at their defaults, result register empty.
// ----------------------------------------------------------------------------
module bitbang_command_link (
  input  logic       clk,
  input  logic       rst_n,
  bcl_in_if.sink     in_ch,
  bcl_out_if.source  out_ch,
  bcl_cfg_if.sink    cfg_ch
);

  bcl_pkg::cfg_regs_t regs;

  bcl_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_ch),
    .regs_o (regs)
  );

  // sequencer state
  bcl_pkg::phase_t                phase_r, phase_nxt;
  logic [bcl_pkg::TICK_W-1:0]     timer_r, timer_nxt;
  logic [bcl_pkg::BIT_IDX_W-1:0]  bit_r, bit_nxt;
  logic [bcl_pkg::CMD_W-1:0]      pend_r, pend_nxt;
  logic [bcl_pkg::NIB_W-1:0]      nib1_r, nib1_nxt;
  logic [bcl_pkg::NIB_W-1:0]      nib2_r, nib2_nxt;
  logic                           send_r, send_nxt;
  logic                           ctrl_r, ctrl_nxt;

  // result register
  logic                       out_valid_r;
  logic                       tx_done_r, tx_done_nxt;
  logic                       tx_ok_r, tx_ok_nxt;
  logic                       rx_valid_r, rx_valid_nxt;
  logic [bcl_pkg::NIB_W-1:0]  rx_cmd_r, rx_cmd_nxt;
  logic                       busy_r;
  logic                       pend_flag_r;
  logic                       line_out_r;
  logic                       ctrl_out_r;

  logic in_fire;
  logic in_send;
  logic elapsed;
  logic [bcl_pkg::TICK_W-1:0] timer_dec;
  logic [bcl_pkg::CMD_W-1:0]  pend_eff;
  logic                       bit_lt8;
  logic                       nib_match;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // shared tick helpers
  assign in_send   = (phase_r == bcl_pkg::PH_TX_BIT) || (phase_r == bcl_pkg::PH_TX_ACK);
  assign elapsed   = (timer_r <= bcl_pkg::TICK_W'(1));
  assign timer_dec = timer_r - bcl_pkg::TICK_W'(1);
  assign bit_lt8   = (bit_r < bcl_pkg::DATA_BITS);
  assign nib_match = (nib1_r == nib2_r) && (nib1_r != '0);

  // command load comes before the idle decision; blocked during a send
  assign pend_eff = (in_ch.load_valid && (in_ch.load_command != '0) && !in_send)
                    ? in_ch.load_command : pend_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      bcl_pkg::PH_IDLE: begin
        if (!in_ch.line_in) begin
          phase_nxt = (pend_eff != '0) ? bcl_pkg::PH_TX_BIT : bcl_pkg::PH_RX_CONFIRM;
        end
      end
      bcl_pkg::PH_TX_BIT: begin
        if (elapsed && !bit_lt8) phase_nxt = bcl_pkg::PH_TX_ACK;
      end
      bcl_pkg::PH_TX_ACK: begin
        if (elapsed) phase_nxt = bcl_pkg::PH_IDLE;
      end
      bcl_pkg::PH_RX_CONFIRM: begin
        if (elapsed) begin
          phase_nxt = in_ch.line_in ? bcl_pkg::PH_IDLE : bcl_pkg::PH_RX_START;
        end
      end
      bcl_pkg::PH_RX_START, bcl_pkg::PH_RX_SAMPLE: begin
        if (elapsed) begin
          if (bit_lt8)        phase_nxt = bcl_pkg::PH_RX_SAMPLE;
          else if (nib_match) phase_nxt = bcl_pkg::PH_RX_HOLD;
          else                phase_nxt = bcl_pkg::PH_IDLE;
        end
      end
      bcl_pkg::PH_RX_HOLD: begin
        if (elapsed) phase_nxt = bcl_pkg::PH_IDLE;
      end
      default: phase_nxt = bcl_pkg::PH_IDLE;
    endcase
  end

  // datapath and per-tick outputs
  always_comb begin
    timer_nxt    = timer_r;
    bit_nxt      = bit_r;
    pend_nxt     = pend_eff;
    nib1_nxt     = nib1_r;
    nib2_nxt     = nib2_r;
    send_nxt     = send_r;
    ctrl_nxt     = ctrl_r;
    tx_done_nxt  = 1'b0;
    tx_ok_nxt    = 1'b0;
    rx_valid_nxt = 1'b0;
    rx_cmd_nxt   = '0;
    case (phase_r)
      bcl_pkg::PH_IDLE: begin
        if (!in_ch.line_in) begin
          if (pend_eff != '0) begin
            ctrl_nxt  = 1'b0;
            send_nxt  = 1'b0;
            bit_nxt   = '0;
            timer_nxt = regs.tx_bit;
          end else begin
            timer_nxt = regs.rx_confirm;
          end
        end
      end
      bcl_pkg::PH_TX_BIT: begin
        timer_nxt = elapsed ? '0 : timer_dec;
        if (elapsed) begin
          if (bit_lt8) begin
            // data bits go out LSB first
            send_nxt  = pend_r[bit_r[2:0]];
            bit_nxt   = bit_r + bcl_pkg::BIT_IDX_W'(1);
            timer_nxt = regs.tx_bit;
          end else begin
            send_nxt  = 1'b1;
            timer_nxt = regs.tx_ack;
          end
        end
      end
      bcl_pkg::PH_TX_ACK: begin
        timer_nxt = elapsed ? '0 : timer_dec;
        if (elapsed) begin
          tx_done_nxt = 1'b1;
          if (in_ch.line_in) begin
            tx_ok_nxt = 1'b1;
            ctrl_nxt  = 1'b1;
            pend_nxt  = '0;
          end
        end
      end
      bcl_pkg::PH_RX_CONFIRM: begin
        timer_nxt = elapsed ? '0 : timer_dec;
        if (elapsed && !in_ch.line_in) begin
          ctrl_nxt  = 1'b0;
          nib1_nxt  = '0;
          nib2_nxt  = '0;
          bit_nxt   = '0;
          timer_nxt = regs.rx_start;
        end
      end
      bcl_pkg::PH_RX_START, bcl_pkg::PH_RX_SAMPLE: begin
        timer_nxt = elapsed ? '0 : timer_dec;
        if (elapsed) begin
          if (bit_lt8) begin
            // two nibbles, each MSB first
            if (!bit_r[2]) nib1_nxt[~bit_r[1:0]] = nib1_r[~bit_r[1:0]] | in_ch.line_in;
            else           nib2_nxt[~bit_r[1:0]] = nib2_r[~bit_r[1:0]] | in_ch.line_in;
            bit_nxt   = bit_r + bcl_pkg::BIT_IDX_W'(1);
            timer_nxt = regs.rx_bit;
          end else if (nib_match) begin
            ctrl_nxt  = 1'b1;
            timer_nxt = regs.rx_hold;
          end
        end
      end
      bcl_pkg::PH_RX_HOLD: begin
        timer_nxt = elapsed ? '0 : timer_dec;
        if (elapsed) begin
          rx_valid_nxt = 1'b1;
          rx_cmd_nxt   = nib1_r;
        end
      end
      default: ;
    endcase
  end

  // state registers advance once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bcl_pkg::PH_IDLE;
      timer_r <= '0;
      bit_r   <= '0;
      pend_r  <= '0;
      nib1_r  <= '0;
      nib2_r  <= '0;
      send_r  <= 1'b1;
      ctrl_r  <= 1'b1;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      bit_r   <= bit_nxt;
      pend_r  <= pend_nxt;
      nib1_r  <= nib1_nxt;
      nib2_r  <= nib2_nxt;
      send_r  <= send_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_out_r  <= send_nxt;
      ctrl_out_r  <= ctrl_nxt;
      tx_done_r   <= tx_done_nxt;
      tx_ok_r     <= tx_ok_nxt;
      rx_valid_r  <= rx_valid_nxt;
      rx_cmd_r    <= rx_cmd_nxt;
      busy_r      <= (phase_nxt != bcl_pkg::PH_IDLE);
      pend_flag_r <= (pend_nxt != '0);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.tx_line      = line_out_r;
  assign out_ch.control_line = ctrl_out_r;
  assign out_ch.tx_done      = tx_done_r;
  assign out_ch.tx_ok        = tx_ok_r;
  assign out_ch.rx_valid     = rx_valid_r;
  assign out_ch.rx_command   = rx_cmd_r;
  assign out_ch.busy_res     = busy_r;
  assign out_ch.pending      = pend_flag_r;

  // checks
  a_send_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == bcl_pkg::PH_TX_BIT) || (phase_r == bcl_pkg::PH_TX_ACK)) |-> (pend_r != '0))
    else $error("send phase with no pending command");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tx_done_r) |-> (!busy_r && line_out_r))
    else $error("send finished but sequencer still busy or line low");

  a_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && tx_ok_r) |-> (tx_done_r && !pend_flag_r && ctrl_out_r))
    else $error("acknowledged send left state inconsistent");

  a_rx_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rx_valid_r) |-> (ctrl_out_r && (rx_cmd_r != '0) && !busy_r))
    else $error("bad receive report");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted tick produced no result");

endmodule

@@ dv/bitbang_command_link_tb.sv @@
// ----------------------------------------------------------------------------
// bitbang_command_link_tb: self-checking testbench for the command link
// Drives one tick beat per item from a partner-line model, predicts every
// result beat with a cycle-free model of the send/receive sequencer, and
// compares each result beat field by field under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitbang_command_link_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_TICKS   = 680;
  localparam int LONG_HOLD      = 300;

  // unused register slots, writes there must be ignored
  localparam logic [bcl_pkg::REG_IDX_W-1:0] REG_NONE_LO = 3'd6;
  localparam logic [bcl_pkg::REG_IDX_W-1:0] REG_NONE_HI = 3'd7;

  typedef enum int {EP_SEND, EP_RECV, EP_NOISE} episode_t;

  typedef struct packed {
    logic                      tx_line;
    logic                      control_line;
    logic                      tx_done;
    logic                      tx_ok;
    logic                      rx_valid;
    logic [bcl_pkg::NIB_W-1:0] rx_command;
    logic                      busy_res;
    logic                      pending;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bcl_in_if  in_ch();
  bcl_out_if out_ch();
  bcl_cfg_if cfg_ch();

  bitbang_command_link dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // link model state, starts at reset values
  bcl_pkg::phase_t               ph       = bcl_pkg::PH_IDLE;
  logic [bcl_pkg::TICK_W-1:0]    tmr      = '0;
  logic [bcl_pkg::BIT_IDX_W-1:0] bidx     = '0;
  logic [bcl_pkg::CMD_W-1:0]     pend_cmd = '0;
  logic [bcl_pkg::NIB_W-1:0]     nib_a    = '0;
  logic [bcl_pkg::NIB_W-1:0]     nib_b    = '0;
  logic                          lvl_tx   = 1'b1;
  logic                          lvl_ctl  = 1'b1;
  bcl_pkg::cfg_regs_t            timing   = '{bcl_pkg::RST_TX_BIT, bcl_pkg::RST_TX_ACK,
                                              bcl_pkg::RST_RX_CONFIRM, bcl_pkg::RST_RX_START,
                                              bcl_pkg::RST_RX_BIT, bcl_pkg::RST_RX_HOLD};

  tick_result_t expected_ticks[$];

  int errors     = 0;
  int ticks_sent = 0;
  int hold_req   = 0;
  bit tx_idle_en  = 1'b0;
  bit rcv_idle_en = 1'b0;

  // one tick of the current wait; 1 when it has run out
  function automatic bit timer_expired();
    if (tmr > 1) begin
      tmr = tmr - 1'b1;
      return 1'b0;
    end
    tmr = '0;
    return 1'b1;
  endfunction

  // advance the link model by one tick and queue the expected result
  task automatic predict_tick(input logic ln, input logic lv,
                              input logic [bcl_pkg::CMD_W-1:0] lc);
    tick_result_t r;
    r = '0;
    if (lv && lc != 0 && !(ph == bcl_pkg::PH_TX_BIT || ph == bcl_pkg::PH_TX_ACK))
      pend_cmd = lc;
    case (ph)
      bcl_pkg::PH_IDLE: begin
        if (!ln) begin
          if (pend_cmd != 0) begin
            lvl_ctl = 1'b0;
            lvl_tx  = 1'b0;
            bidx    = '0;
            tmr     = timing.tx_bit;
            ph      = bcl_pkg::PH_TX_BIT;
          end else begin
            tmr = timing.rx_confirm;
            ph  = bcl_pkg::PH_RX_CONFIRM;
          end
        end
      end
      bcl_pkg::PH_TX_BIT: begin
        if (timer_expired()) begin
          if (bidx < bcl_pkg::DATA_BITS) begin
            lvl_tx = pend_cmd[bidx];
            bidx   = bidx + 1'b1;
            tmr    = timing.tx_bit;
          end else begin
            lvl_tx = 1'b1;
            tmr    = timing.tx_ack;
            ph     = bcl_pkg::PH_TX_ACK;
          end
        end
      end
      bcl_pkg::PH_TX_ACK: begin
        if (timer_expired()) begin
          r.tx_done = 1'b1;
          if (ln) begin
            r.tx_ok  = 1'b1;
            lvl_ctl  = 1'b1;
            pend_cmd = '0;
          end
          ph = bcl_pkg::PH_IDLE;
        end
      end
      bcl_pkg::PH_RX_CONFIRM: begin
        if (timer_expired()) begin
          if (!ln) begin
            lvl_ctl = 1'b0;
            nib_a   = '0;
            nib_b   = '0;
            bidx    = '0;
            tmr     = timing.rx_start;
            ph      = bcl_pkg::PH_RX_START;
          end else begin
            ph = bcl_pkg::PH_IDLE;
          end
        end
      end
      bcl_pkg::PH_RX_START, bcl_pkg::PH_RX_SAMPLE: begin
        if (timer_expired()) begin
          if (bidx < bcl_pkg::DATA_BITS) begin
            // first copy fills bits 3..0, second copy likewise, MSB first
            if (bidx < bcl_pkg::NIB_W)
              nib_a[bcl_pkg::NIB_W-1-bidx] = ln;
            else
              nib_b[bcl_pkg::DATA_BITS-1-bidx] = ln;
            bidx = bidx + 1'b1;
            tmr  = timing.rx_bit;
            ph   = bcl_pkg::PH_RX_SAMPLE;
          end else if (nib_a == nib_b && nib_a != 0) begin
            lvl_ctl = 1'b1;
            tmr     = timing.rx_hold;
            ph      = bcl_pkg::PH_RX_HOLD;
          end else begin
            ph = bcl_pkg::PH_IDLE;
          end
        end
      end
      bcl_pkg::PH_RX_HOLD: begin
        if (timer_expired()) begin
          r.rx_valid   = 1'b1;
          r.rx_command = nib_a;
          ph           = bcl_pkg::PH_IDLE;
        end
      end
      default: ph = bcl_pkg::PH_IDLE;
    endcase
    r.tx_line      = lvl_tx;
    r.control_line = lvl_ctl;
    r.busy_res     = (ph != bcl_pkg::PH_IDLE);
    r.pending      = (pend_cmd != 0);
    expected_ticks.push_back(r);
  endtask

  // send one tick beat, with an optional random gap in front
  task automatic send_tick(input logic ln, input logic lv,
                           input logic [bcl_pkg::CMD_W-1:0] lc);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.line_in      <= ln;
    in_ch.load_valid   <= lv;
    in_ch.load_command <= lc;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
    predict_tick(ln, lv, lc);
  endtask

  // register write once every outstanding result beat has come back
  task automatic write_reg(input logic [bcl_pkg::REG_IDX_W-1:0] idx,
                           input logic [bcl_pkg::TICK_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      bcl_pkg::REG_TX_BIT:     timing.tx_bit     = val;
      bcl_pkg::REG_TX_ACK:     timing.tx_ack     = val;
      bcl_pkg::REG_RX_CONFIRM: timing.rx_confirm = val;
      bcl_pkg::REG_RX_START:   timing.rx_start   = val;
      bcl_pkg::REG_RX_BIT:     timing.rx_bit     = val;
      bcl_pkg::REG_RX_HOLD:    timing.rx_hold    = val;
      default: ;
    endcase
  endtask

  // mostly short delays, sometimes zero or a bit longer
  function automatic logic [bcl_pkg::TICK_W-1:0] rand_ticks();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick < 4) return bcl_pkg::TICK_W'($urandom_range(6, 12));
    return bcl_pkg::TICK_W'($urandom_range(1, 5));
  endfunction

  task automatic program_regs();
    write_reg(bcl_pkg::REG_TX_BIT,     rand_ticks());
    write_reg(bcl_pkg::REG_TX_ACK,     rand_ticks());
    write_reg(bcl_pkg::REG_RX_CONFIRM, rand_ticks());
    write_reg(bcl_pkg::REG_RX_START,   rand_ticks());
    write_reg(bcl_pkg::REG_RX_BIT,     rand_ticks());
    write_reg(bcl_pkg::REG_RX_HOLD,    rand_ticks());
  endtask

  // partner side of one exchange; returns with the sequencer idle
  task automatic run_episode(input episode_t kind, input logic [bcl_pkg::CMD_W-1:0] cmd,
                             input logic [7:0] frame, input bit ack_hi,
                             input bit abort, input bit busy_load, input int noise_len);
    logic ln;
    logic lv;
    case (kind)
      EP_SEND: begin
        send_tick(1'b0, 1'b1, cmd);
      end
      EP_RECV: begin
        send_tick(1'b0, busy_load, cmd);
      end
      default: begin
        repeat (noise_len)
          send_tick(1'($urandom_range(0, 1)), $urandom_range(0, 6) == 0,
                    bcl_pkg::CMD_W'($urandom_range(0, 255)));
      end
    endcase
    while (ph != bcl_pkg::PH_IDLE) begin
      ln = 1'($urandom_range(0, 1));
      case (ph)
        bcl_pkg::PH_TX_ACK:     if (tmr <= 1) ln = ack_hi;
        bcl_pkg::PH_RX_CONFIRM: ln = abort && tmr <= 1;
        bcl_pkg::PH_RX_START, bcl_pkg::PH_RX_SAMPLE:
          if (bidx < bcl_pkg::DATA_BITS) ln = frame[bcl_pkg::DATA_BITS-1-bidx];
        default: ;
      endcase
      // noise drains with the line high so the sequence winds down
      if (kind == EP_NOISE) ln = 1'b1;
      lv = busy_load || ($urandom_range(0, 9) == 0);
      send_tick(ln, lv && kind != EP_NOISE, bcl_pkg::CMD_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random_episode();
    logic [bcl_pkg::NIB_W-1:0] nib;
    logic [7:0]                frame;
    int                        pick;
    int                        form;
    nib  = bcl_pkg::NIB_W'($urandom_range(1, 15));
    form = $urandom_range(0, 9);
    if (form == 0)     frame = '0;
    else if (form < 3) frame = 8'($urandom_range(0, 255));
    else               frame = {nib, nib};
    pick = $urandom_range(0, 9);
    if (pick < 4)
      run_episode(EP_SEND, bcl_pkg::CMD_W'($urandom_range(1, 255)), frame,
                  $urandom_range(0, 3) != 0, 1'b0, $urandom_range(0, 7) == 0, 0);
    else if (pick < 8)
      run_episode(EP_RECV, bcl_pkg::CMD_W'($urandom_range(0, 255)), frame, 1'b1,
                  $urandom_range(0, 7) == 0, $urandom_range(0, 9) == 0, 0);
    else
      run_episode(EP_NOISE, '0, frame, 1'b1, 1'b0, 1'b0, $urandom_range(1, 12));
  endtask

  // ---- tests ----

  // reset state: idle ticks, then a load with the line high only marks pending
  task automatic test_reset_state();
    tx_idle_en  = 1'b0;
    rcv_idle_en = 1'b0;
    repeat (3) send_tick(1'b1, 1'b0, '0);
    send_tick(1'b1, 1'b1, 8'h3C);
    send_tick(1'b1, 1'b0, '0);
  endtask

  // corner cases at the shortest delays
  task automatic test_directed();
    tx_idle_en  = 1'b1;
    rcv_idle_en = 1'b1;
    write_reg(bcl_pkg::REG_TX_BIT,     16'd1);
    write_reg(bcl_pkg::REG_TX_ACK,     16'd1);
    write_reg(bcl_pkg::REG_RX_CONFIRM, 16'd1);
    write_reg(bcl_pkg::REG_RX_START,   16'd1);
    write_reg(bcl_pkg::REG_RX_BIT,     16'd1);
    write_reg(bcl_pkg::REG_RX_HOLD,    16'd1);
    run_episode(EP_SEND, 8'hFF, '0, 1'b1, 1'b0, 1'b0, 0);
    // no ack: command stays pending, then a zero load leaves it for the retry
    run_episode(EP_SEND, 8'h01, '0, 1'b0, 1'b0, 1'b0, 0);
    run_episode(EP_SEND, 8'h00, '0, 1'b1, 1'b0, 1'b1, 0);
    // a later load replaces the pending one
    send_tick(1'b1, 1'b1, 8'h5A);
    send_tick(1'b1, 1'b1, 8'hA5);
    run_episode(EP_SEND, 8'h00, '0, 1'b1, 1'b0, 1'b0, 0);
    run_episode(EP_RECV, '0, 8'hFF, 1'b1, 1'b0, 1'b0, 0);
    run_episode(EP_RECV, '0, 8'h11, 1'b1, 1'b0, 1'b0, 0);
    run_episode(EP_RECV, '0, 8'h12, 1'b1, 1'b0, 1'b0, 0);
    run_episode(EP_RECV, '0, 8'h00, 1'b1, 1'b0, 1'b0, 0);
    run_episode(EP_RECV, '0, 8'h77, 1'b1, 1'b1, 1'b0, 0);
    // zero delays act as one tick; writes to unused slots change nothing
    write_reg(bcl_pkg::REG_TX_BIT,     16'd0);
    write_reg(bcl_pkg::REG_TX_ACK,     16'd0);
    write_reg(bcl_pkg::REG_RX_CONFIRM, 16'd0);
    write_reg(bcl_pkg::REG_RX_START,   16'd0);
    write_reg(bcl_pkg::REG_RX_BIT,     16'd0);
    write_reg(bcl_pkg::REG_RX_HOLD,    16'd0);
    write_reg(REG_NONE_LO,             16'hFFFF);
    write_reg(REG_NONE_HI,             16'h5555);
    run_episode(EP_SEND, 8'h96, '0, 1'b1, 1'b0, 1'b0, 0);
    run_episode(EP_RECV, '0, 8'h99, 1'b1, 1'b0, 1'b0, 0);
  endtask

  // long acknowledge wait, past the low byte of the timer
  task automatic test_long_timer();
    tx_idle_en  = 1'b0;
    rcv_idle_en = 1'b0;
    write_reg(bcl_pkg::REG_TX_BIT, 16'd1);
    write_reg(bcl_pkg::REG_TX_ACK, 16'h0100);
    run_episode(EP_SEND, 8'hC3, '0, 1'b1, 1'b0, 1'b0, 0);
  endtask

  // long receiver hold-off, then a sender pause until everything is back
  task automatic test_backpressure();
    int stop_at;
    tx_idle_en  = 1'b0;
    rcv_idle_en = 1'b0;
    program_regs();
    hold_req = LONG_HOLD;
    stop_at  = ticks_sent + 150;
    while (ticks_sent < stop_at) run_random_episode();
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    rcv_idle_en = 1'b1;
    stop_at = ticks_sent + 40;
    while (ticks_sent < stop_at) run_random_episode();
  endtask

  task automatic test_random();
    int stop_at;
    int blk;
    for (blk = 0; blk < 4; blk++) begin
      program_regs();
      tx_idle_en  = (blk != 1);
      rcv_idle_en = (blk != 3);
      stop_at = ticks_sent + RANDOM_TICKS / 4;
      while (ticks_sent < stop_at) run_random_episode();
    end
  endtask

  // ---- result checking ----

  task automatic cmp_field(input string fname, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  task automatic check_beat();
    tick_result_t want;
    if (expected_ticks.size() == 0) begin
      errors++;
      $display("%0t: result beat with none expected, expected none, got %0h", $time,
               {out_ch.tx_line, out_ch.control_line, out_ch.tx_done, out_ch.tx_ok,
                out_ch.rx_valid, out_ch.rx_command, out_ch.busy_res, out_ch.pending});
      return;
    end
    want = expected_ticks.pop_front();
    cmp_field("tx_line",      want.tx_line,      out_ch.tx_line);
    cmp_field("control_line", want.control_line, out_ch.control_line);
    cmp_field("tx_done",      want.tx_done,      out_ch.tx_done);
    cmp_field("tx_ok",        want.tx_ok,        out_ch.tx_ok);
    cmp_field("rx_valid",     want.rx_valid,     out_ch.rx_valid);
    cmp_field("rx_command",   want.rx_command,   out_ch.rx_command);
    cmp_field("busy_res",     want.busy_res,     out_ch.busy_res);
    cmp_field("pending",      want.pending,      out_ch.pending);
  endtask

  // receiver: checks each beat, stalls per beat, and serves a long hold-off
  int stall_left = 0;
  int hold_left  = 0;
  always @(posedge clk) begin : result_sink
    logic nxt;
    if (out_ch.valid && out_ch.ready) begin
      check_beat();
      stall_left = rcv_idle_en ? $urandom_range(0, 17) : 0;
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b0;
    end else begin
      nxt = 1'b1;
    end
    out_ch.ready <= nxt;
  end

  // watchdog on cycles with no beat on any channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** bitbang_command_link: FAILED **");
        $finish;
      end
    end
  end

  // ---- main sequence ----
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.line_in      = 1'b1;
    in_ch.load_valid   = 1'b0;
    in_ch.load_command = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed();
    test_long_timer();
    test_backpressure();
    test_random();

    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_ticks.size() == 0) begin
      $display("** bitbang_command_link: PASSED **");
    end else begin
      $display("** bitbang_command_link: FAILED **");
    end
    $finish;
  end

endmodule
